[hw/rtl/lpcr_pkg.sv]
// Shared constants, types and sequencer states for the lowest-power channel ranker.
`default_nettype none
package lpcr_pkg;

  localparam int SLOTS     = 8;
  localparam int MAX_ITEMS = 4096;

  localparam int FREQ_W  = 16;
  localparam int POWER_W = 32;
  localparam int RANK_W  = 3;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
  localparam int SUM_W   = POWER_W + CNT_W;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic [POWER_W-1:0] POWER_EMPTY = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_LOAD,
    ST_SEND
  } seq_state_t;

  typedef struct packed {
    logic              start;
    logic              clear;
    logic [SLOT_W-1:0] rd_idx;
  } slot_ctl_t;

  typedef struct packed {
    logic               done;
    logic [FREQ_W-1:0]  rd_freq;
    logic [POWER_W-1:0] rd_pwr;
  } slot_sts_t;

endpackage
`default_nettype wire

[hw/rtl/lpcr_if.sv]
// Valid/ready channel interfaces for candidate and ranked-result transactions.
`default_nettype none
interface lpcr_in_if
  import lpcr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [FREQ_W-1:0]  frequency;
  logic [POWER_W-1:0] noise_power;
  logic               last_item;

  modport source (output valid, frequency, noise_power, last_item, input ready);
  modport sink   (input valid, frequency, noise_power, last_item, output ready);
endinterface

interface lpcr_out_if
  import lpcr_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [RANK_W-1:0]  rank;
  logic [FREQ_W-1:0]  ranked_frequency;
  logic [POWER_W-1:0] ranked_power;
  logic [POWER_W-1:0] mean_power;
  logic               last_result;

  modport source (output valid, rank, ranked_frequency, ranked_power, mean_power,
                  last_result, input ready);
  modport sink   (input valid, rank, ranked_frequency, ranked_power, mean_power,
                  last_result, output ready);
endinterface
`default_nettype wire

[hw/rtl/lpcr_slot_list.sv]
// Sorted slot list with one shared compare-and-shift unit stepping over the slots.
`default_nettype none
module lpcr_slot_list
  import lpcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire slot_ctl_t          ctl,
  input  wire logic [FREQ_W-1:0]  in_freq,
  input  wire logic [POWER_W-1:0] in_pwr,
  output slot_sts_t               sts
);

  logic [POWER_W-1:0] pow_r  [SLOTS];
  logic [FREQ_W-1:0]  freq_r [SLOTS];
  logic [POWER_W-1:0] carry_pwr_r;
  logic [FREQ_W-1:0]  carry_freq_r;
  logic               shift_r;
  logic               busy_r;
  logic [SLOT_W-1:0]  idx_r;

  logic [SLOT_W-1:0]  sel;
  logic [POWER_W-1:0] cur_pwr;
  logic [FREQ_W-1:0]  cur_freq;
  logic               take;
  logic               at_end;

  assign sel      = busy_r ? idx_r : ctl.rd_idx;
  assign cur_pwr  = pow_r[sel];
  assign cur_freq = freq_r[sel];
  // once inserted, every later slot moves down one place
  assign take     = shift_r || (carry_pwr_r < cur_pwr);
  assign at_end   = (idx_r == SLOT_W'(SLOTS - 1));

  assign sts.done    = busy_r && at_end;
  assign sts.rd_freq = cur_freq;
  assign sts.rd_pwr  = cur_pwr;

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      for (int i = 0; i < SLOTS; i++) begin
        pow_r[i]  <= POWER_EMPTY;
        freq_r[i] <= '0;
      end
    end else if (busy_r && take) begin
      pow_r[idx_r]  <= carry_pwr_r;
      freq_r[idx_r] <= carry_freq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      shift_r <= 1'b0;
      idx_r   <= '0;
    end else if (ctl.start) begin
      busy_r  <= 1'b1;
      shift_r <= 1'b0;
      idx_r   <= '0;
    end else if (busy_r) begin
      shift_r <= take;
      idx_r   <= idx_r + SLOT_W'(1);
      if (at_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      carry_pwr_r  <= in_pwr;
      carry_freq_r <= in_freq;
    end else if (busy_r && take) begin
      carry_pwr_r  <= cur_pwr;
      carry_freq_r <= cur_freq;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lpcr_div.sv]
// Restoring divider, one quotient bit per cycle, for the mean power.
`default_nettype none
module lpcr_div
  import lpcr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [CNT_W-1:0]   divisor,
  output logic                    done,
  output logic [POWER_W-1:0]      quotient
);

  logic [SUM_W-1:0]  dq_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign trial = {rem_r, dq_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  assign done     = done_r;
  assign quotient = dq_r[POWER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/lowest_power_channel_ranker.sv]
// Lowest-power channel ranker top level: sequencer, power accumulator and result register.
// A non-final item is accepted, then the shared comparator visits each slot in turn.
// A final item then runs the bit-serial mean divider, then loads and sends each ranked
// result in turn, stalling while the sink is not ready. One item at a time: in_ch.ready
// is low from acceptance until the scan ends (a final item: until its last result is taken).
// Synchronous active-low reset empties the slots, zeroes sum and count, and idles the sequencer.
`default_nettype none
module lowest_power_channel_ranker
  import lpcr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpcr_in_if.sink     in_ch,
  lpcr_out_if.source  out_ch
);

  seq_state_t state_r, state_nxt;

  logic [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               last_r;
  logic [SLOT_W-1:0]  k_r;
  logic [POWER_W-1:0] mean_r;
  logic [RANK_W-1:0]  rank_r;
  logic [FREQ_W-1:0]  rfreq_r;
  logic [POWER_W-1:0] rpwr_r;
  logic               rlast_r;

  slot_ctl_t          slot_ctl;
  slot_sts_t          slot_sts;
  logic               div_start;
  logic               div_done;
  logic [POWER_W-1:0] div_q;

  logic               in_hs;
  logic               out_hs;
  logic               k_end;

  assign in_hs  = in_ch.valid && in_ch.ready;
  assign out_hs = out_ch.valid && out_ch.ready;
  assign k_end  = (k_r == SLOT_W'(SLOTS - 1));

  lpcr_slot_list u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .in_freq (in_ch.frequency),
    .in_pwr  (in_ch.noise_power),
    .sts     (slot_sts)
  );

  lpcr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_hs) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (slot_sts.done) state_nxt = last_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV:  if (div_done) state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_SEND;
      ST_SEND: begin
        if (out_hs) state_nxt = k_end ? ST_IDLE : ST_LOAD;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready     = (state_r == ST_IDLE);
    out_ch.valid    = (state_r == ST_SEND);
    slot_ctl.start  = in_hs;
    slot_ctl.clear  = (state_r == ST_SEND) && out_hs && k_end;
    slot_ctl.rd_idx = k_r;
    div_start       = (state_r == ST_SCAN) && slot_sts.done && last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r   <= '0;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (slot_ctl.clear) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (in_hs && (cnt_r < CNT_W'(MAX_ITEMS))) begin
        sum_r <= sum_r + SUM_W'(in_ch.noise_power);
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (div_done) begin
        k_r <= '0;
      end else if (out_hs) begin
        k_r <= k_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_hs) begin
      last_r <= in_ch.last_item;
    end
    if (div_done) begin
      mean_r <= (cnt_r == '0) ? '0 : div_q;
    end
    if (state_r == ST_LOAD) begin
      rank_r  <= RANK_W'(k_r);
      rfreq_r <= slot_sts.rd_freq;
      rpwr_r  <= slot_sts.rd_pwr;
      rlast_r <= k_end;
    end
  end

  assign out_ch.rank             = rank_r;
  assign out_ch.ranked_frequency = rfreq_r;
  assign out_ch.ranked_power     = rpwr_r;
  assign out_ch.mean_power       = mean_r;
  assign out_ch.last_result      = rlast_r;

endmodule
`default_nettype wire

[hw/rtl/lpcr_checker.sv]
// Port-level assertions for the ranker, bound to the top level.
`default_nettype none
module lpcr_checker
  import lpcr_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               in_last_item,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [RANK_W-1:0]  out_rank,
  input wire logic [FREQ_W-1:0]  out_ranked_frequency,
  input wire logic [POWER_W-1:0] out_ranked_power,
  input wire logic [POWER_W-1:0] out_mean_power,
  input wire logic               out_last_result
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rank) &&
      $stable(out_ranked_frequency) && $stable(out_ranked_power) &&
      $stable(out_mean_power) && $stable(out_last_result))
    else $error("result transaction changed while stalled");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_no_result_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_last_item |=> !out_valid)
    else $error("result after a non-final item");

  a_rank_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_result |=> !out_valid ##1
      (out_valid && out_rank == $past(out_rank, 2) + RANK_W'(1) &&
       out_mean_power == $past(out_mean_power, 2)))
    else $error("ranked results out of sequence");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_result |=> !out_valid && in_ready)
    else $error("block not idle after final result");

endmodule

bind lowest_power_channel_ranker lpcr_checker u_lpcr_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .in_last_item         (in_ch.last_item),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_rank             (out_ch.rank),
  .out_ranked_frequency (out_ch.ranked_frequency),
  .out_ranked_power     (out_ch.ranked_power),
  .out_mean_power       (out_ch.mean_power),
  .out_last_result      (out_ch.last_result)
);
`default_nettype wire

[tb/lowest_power_channel_ranker_tb.sv]
// Self-checking testbench for the lowest-power channel ranker: random and directed candidate runs.
`timescale 1ns / 1ps
module lowest_power_channel_ranker_tb;
  import lpcr_pkg::*;

  typedef struct {
    logic [RANK_W-1:0]  rank;
    logic [FREQ_W-1:0]  frequency;
    logic [POWER_W-1:0] power;
    logic [POWER_W-1:0] mean;
    logic               last;
  } ranked_entry_t;

  class ranked_list_model;
    logic [POWER_W-1:0] slot_pwr[SLOTS];
    logic [FREQ_W-1:0]  slot_frq[SLOTS];
    logic [SUM_W-1:0]   power_total;
    logic [CNT_W-1:0]   items_seen;
    ranked_entry_t      ranked_q[$];
    int                 fail_count;

    function new();
      fail_count = 0;
      clear_run();
    endfunction

    function void clear_run();
      for (int i = 0; i < SLOTS; i++) begin
        slot_pwr[i] = POWER_EMPTY;
        slot_frq[i] = '0;
      end
      power_total = '0;
      items_seen  = '0;
    endfunction

    function int pending();
      return ranked_q.size();
    endfunction

    // insertion by strict less-than keeps the earlier entry ahead on a tie
    function void add_candidate(logic [FREQ_W-1:0] frq, logic [POWER_W-1:0] pwr, logic fin);
      int            pos;
      logic [SUM_W-1:0] quotient;
      ranked_entry_t entry;
      pos = SLOTS;
      for (int i = SLOTS - 1; i >= 0; i--)
        if (pwr < slot_pwr[i]) pos = i;
      if (pos < SLOTS) begin
        for (int j = SLOTS - 1; j > pos; j--) begin
          slot_pwr[j] = slot_pwr[j-1];
          slot_frq[j] = slot_frq[j-1];
        end
        slot_pwr[pos] = pwr;
        slot_frq[pos] = frq;
      end
      if (items_seen < MAX_ITEMS) begin
        power_total = power_total + SUM_W'(pwr);
        items_seen  = items_seen + 1'b1;
      end
      if (!fin) return;
      quotient = (items_seen != 0) ? power_total / SUM_W'(items_seen) : '0;
      for (int k = 0; k < SLOTS; k++) begin
        entry.rank      = RANK_W'(k);
        entry.frequency = slot_frq[k];
        entry.power     = slot_pwr[k];
        entry.mean      = quotient[POWER_W-1:0];
        entry.last      = (k == SLOTS - 1);
        ranked_q.push_back(entry);
      end
      clear_run();
    endfunction

    function void compare_field(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_ranked(logic [RANK_W-1:0] rank, logic [FREQ_W-1:0] frq,
                               logic [POWER_W-1:0] pwr, logic [POWER_W-1:0] mean,
                               logic fin);
      ranked_entry_t want;
      if (ranked_q.size() == 0) begin
        $error("unexpected ranked transaction: rank %0d frequency %0h", rank, frq);
        fail_count++;
        return;
      end
      want = ranked_q.pop_front();
      compare_field("rank", 64'(want.rank), 64'(rank));
      compare_field("ranked_frequency", 64'(want.frequency), 64'(frq));
      compare_field("ranked_power", 64'(want.power), 64'(pwr));
      compare_field("mean_power", 64'(want.mean), 64'(mean));
      compare_field("last_result", 64'(want.last), 64'(fin));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  ranked_list_model sb = new();

  lpcr_in_if  in_ch();
  lpcr_out_if out_ch();

  lowest_power_channel_ranker uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_ranked(out_ch.rank, out_ch.ranked_frequency, out_ch.ranked_power,
                      out_ch.mean_power, out_ch.last_result);
  end

  task automatic send_candidate(input logic [FREQ_W-1:0] frq, input logic [POWER_W-1:0] pwr,
                                input logic fin);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.frequency   <= frq;
    in_ch.noise_power <= pwr;
    in_ch.last_item   <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.add_candidate(frq, pwr, fin);
    @(negedge clk);
  endtask

  // mostly wide random powers, with clusters of small values for ties and the empty marker
  function automatic logic [POWER_W-1:0] pick_power();
    logic [POWER_W-1:0] pwr;
    case ($urandom_range(9))
      5, 6:    pwr = $urandom_range(7);
      7:       pwr = POWER_EMPTY;
      8:       pwr = POWER_EMPTY - $urandom_range(3);
      9:       pwr = $urandom >> $urandom_range(31);
      default: pwr = $urandom;
    endcase
    return pwr;
  endfunction

  task automatic random_phase(input int target);
    int sent;
    int len;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(16, 1);
      for (int i = 0; i < len; i++)
        send_candidate(FREQ_W'($urandom), pick_power(), i == len - 1);
      sent += len;
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    int wait_cycles;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.frequency   = '0;
    in_ch.noise_power = '0;
    in_ch.last_item   = 1'b0;
    in_idle_pct       = 0;
    out_idle_pct      = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-item run: most slots stay empty
    send_candidate(16'hFFFF, 32'h0, 1'b1);
    // overflowing run with ties, zero, the empty marker and near-maximum power
    send_candidate(16'h0000, POWER_EMPTY, 1'b0);
    send_candidate(16'h0001, 32'd5, 1'b0);
    send_candidate(16'h0002, 32'd5, 1'b0);
    send_candidate(16'h0003, 32'd3, 1'b0);
    send_candidate(16'h0004, 32'hFFFF_FFFE, 1'b0);
    send_candidate(16'h0005, 32'd0, 1'b0);
    send_candidate(16'h0006, 32'd7, 1'b0);
    send_candidate(16'h0007, 32'd9, 1'b0);
    send_candidate(16'h0008, 32'd1, 1'b0);
    send_candidate(16'h0009, 32'd2, 1'b0);
    send_candidate(16'h000A, 32'd4, 1'b0);
    send_candidate(16'hAAAA, 32'd5, 1'b0);
    send_candidate(16'h5555, 32'h8000_0000, 1'b1);
    // only empty-marker powers: every slot stays unused
    send_candidate(16'h1234, POWER_EMPTY, 1'b0);
    send_candidate(16'h4321, POWER_EMPTY, 1'b1);
    drain_results();

    in_idle_pct  = 20;
    out_idle_pct = 75;
    random_phase(65);
    drain_results();
    in_idle_pct  = 75;
    out_idle_pct = 20;
    random_phase(65);
    drain_results();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_phase(65);

    in_ch.valid <= 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d ranked transactions never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[lowest_power_channel_ranker.f]
hw/rtl/lpcr_pkg.sv
hw/rtl/lpcr_if.sv
hw/rtl/lpcr_slot_list.sv
hw/rtl/lpcr_div.sv
hw/rtl/lowest_power_channel_ranker.sv
hw/rtl/lpcr_checker.sv
tb/lowest_power_channel_ranker_tb.sv
